// File: src/ntc_pkg.sv
`timescale 1ns / 1ps

package ntc_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 8;
  localparam int BUTTON_W = 4;
  localparam int ACTION_W = 3;
  localparam int CLASS_W  = 2;
  localparam int DIST_W   = 9;
  localparam int TMPL_W   = 32;
  localparam int THR_W    = 9;
  localparam int HOLD_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CHAN = 4;
  localparam int NUM_TMPL = 4;

  localparam logic [DIST_W-1:0] DIST_MAX = 9'd511;
  localparam logic [HOLD_W-1:0] RUN_MAX  = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT     = 3'd5;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 9'd30;
  localparam logic [HOLD_W-1:0] HOLD_RESET      = 8'd12;

  // Button codes.
  localparam logic [BUTTON_W-1:0] BTN_NONE     = 4'd0;
  localparam logic [BUTTON_W-1:0] BTN_UP       = 4'd1;
  localparam logic [BUTTON_W-1:0] BTN_DOWN     = 4'd2;
  localparam logic [BUTTON_W-1:0] BTN_ATTACK   = 4'd4;
  localparam logic [BUTTON_W-1:0] BTN_CLASSIFY = 4'd8;

  // Tracked class value meaning no class is being counted.
  localparam logic [2:0] NO_CLASS = 3'd4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE   = 3'd0,
    ACT_UP     = 3'd1,
    ACT_DOWN   = 3'd2,
    ACT_ATTACK = 3'd3,
    ACT_BONUS  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACC,
    ST_RLOAD,
    ST_ROOT,
    ST_BEST,
    ST_FIN
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       capture;
    logic       acc_en;
    logic [1:0] chan;
    logic [1:0] tmpl;
    logic       root_load;
    logic       root_step;
    logic       best_upd;
    logic       commit;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic classify;
  } stat_t;

endpackage

// File: src/ntc_ctrl.sv
`timescale 1ns / 1ps

module ntc_ctrl #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ntc_pkg::stat_t stat,
  output ntc_pkg::cmd_t  cmd
);
  import ntc_pkg::*;

  localparam int ROOT_BITS = SAMPLE_BITS + 1;
  localparam int ITER_W    = $clog2(ROOT_BITS);

  state_t            state_r, state_nxt;
  logic [1:0]        chan_r, chan_nxt;
  logic [1:0]        tmpl_r, tmpl_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              iter_last;
  logic              can_commit;

  assign iter_last  = (iter_r == ITER_W'(ROOT_BITS - 1));
  assign can_commit = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = stat.classify ? ST_ACC : ST_FIN;
      ST_ACC:   if (chan_r == 2'd3) state_nxt = ST_RLOAD;
      ST_RLOAD: state_nxt = ST_ROOT;
      ST_ROOT:  if (iter_last) state_nxt = ST_BEST;
      ST_BEST:  state_nxt = (tmpl_r == 2'd3) ? ST_FIN : ST_ACC;
      ST_FIN:   if (can_commit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and counter updates.
  always_comb begin
    cmd           = '0;
    cmd.chan      = chan_r;
    cmd.tmpl      = tmpl_r;
    in_ready      = 1'b0;
    chan_nxt      = chan_r;
    tmpl_nxt      = tmpl_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CHECK: begin
        chan_nxt = 2'd0;
        tmpl_nxt = 2'd0;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        chan_nxt   = chan_r + 2'd1;
      end
      ST_RLOAD: begin
        cmd.root_load = 1'b1;
        iter_nxt      = '0;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        iter_nxt      = iter_r + ITER_W'(1);
      end
      ST_BEST: begin
        cmd.best_upd = 1'b1;
        tmpl_nxt     = tmpl_r + 2'd1;
      end
      ST_FIN: begin
        if (can_commit) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chan_r      <= '0;
      tmpl_r      <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      tmpl_r      <= tmpl_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: src/ntc_dp.sv
`timescale 1ns / 1ps

module ntc_dp #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ntc_pkg::cmd_t                       cmd,
  output ntc_pkg::stat_t                      stat,
  input  logic [ntc_pkg::SAMPLE_W-1:0]        in_sample_a,
  input  logic [ntc_pkg::SAMPLE_W-1:0]        in_sample_b,
  input  logic [ntc_pkg::SAMPLE_W-1:0]        in_sample_c,
  input  logic [ntc_pkg::SAMPLE_W-1:0]        in_sample_d,
  input  logic [ntc_pkg::BUTTON_W-1:0]        in_button_status,
  input  logic                                cfg_valid,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ntc_pkg::TMPL_W-1:0]          cfg_data,
  output logic [ntc_pkg::ACTION_W-1:0]        out_action,
  output logic [ntc_pkg::CLASS_W-1:0]         out_best_class,
  output logic [ntc_pkg::DIST_W-1:0]          out_best_distance,
  output logic                                out_classified
);
  import ntc_pkg::*;

  localparam int SB        = SAMPLE_BITS;
  localparam int SQ_W      = 2 * SB;
  localparam int SUM_W     = 2 * SB + 2;
  localparam int ROOT_BITS = SB + 1;
  localparam int REM_W     = ROOT_BITS + 3;
  localparam int CMP_W     = (ROOT_BITS > DIST_W) ? ROOT_BITS : DIST_W;
  localparam int TPAD_W    = 4 * SB + TMPL_W;

  // Configuration registers.
  logic [TMPL_W-1:0] tmpl_r [NUM_TMPL];
  logic [THR_W-1:0]  thr_r;
  logic [HOLD_W-1:0] hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TMPL; i++) tmpl_r[i] <= '0;
      thr_r  <= THRESHOLD_RESET;
      hold_r <= HOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMPLATE_ZERO:   tmpl_r[0] <= cfg_data;
        REG_TEMPLATE_ONE:    tmpl_r[1] <= cfg_data;
        REG_TEMPLATE_TWO:    tmpl_r[2] <= cfg_data;
        REG_TEMPLATE_THREE:  tmpl_r[3] <= cfg_data;
        REG_MATCH_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
        REG_HOLD_COUNT:      hold_r <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured transaction. Samples are masked to the sample width.
  logic [SB-1:0]       samp_r [NUM_CHAN];
  logic [BUTTON_W-1:0] btn_r;
  logic [SB+SAMPLE_W-1:0] sw [NUM_CHAN];

  assign sw[0] = {{SB{1'b0}}, in_sample_a};
  assign sw[1] = {{SB{1'b0}}, in_sample_b};
  assign sw[2] = {{SB{1'b0}}, in_sample_c};
  assign sw[3] = {{SB{1'b0}}, in_sample_d};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < NUM_CHAN; i++) samp_r[i] <= sw[i][SB-1:0];
      btn_r <= in_button_status;
    end
  end

  assign stat.classify = (btn_r == BTN_CLASSIFY);

  // Squared difference of one channel, accumulated per template.
  logic [TPAD_W-1:0] tpad;
  logic [SB-1:0]     tfield [NUM_CHAN];
  logic [SB-1:0]     cur_t, cur_s, diff;
  logic [SQ_W-1:0]   sq;
  logic [SUM_W-1:0]  acc_r, acc_nxt;

  assign tpad = {{(4 * SB){1'b0}}, tmpl_r[cmd.tmpl]};
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_field
    assign tfield[c] = tpad[c*SB +: SB];
  end

  assign cur_t   = tfield[cmd.chan];
  assign cur_s   = samp_r[cmd.chan];
  assign diff    = (cur_t > cur_s) ? (cur_t - cur_s) : (cur_s - cur_t);
  assign sq      = SQ_W'(diff) * SQ_W'(diff);
  assign acc_nxt = ((cmd.chan == 2'd0) ? '0 : acc_r) + SUM_W'(sq);

  always_ff @(posedge clk) begin
    if (cmd.acc_en) acc_r <= acc_nxt;
  end

  // Digit-by-digit square root, one result bit per step.
  logic [SUM_W-1:0]     rad_r;
  logic [REM_W-1:0]     rem_r, rem_t, trial;
  logic [ROOT_BITS-1:0] root_r;
  logic                 ge;

  assign rem_t = {rem_r[REM_W-3:0], rad_r[SUM_W-1 -: 2]};
  assign trial = REM_W'({root_r, 2'b01});
  assign ge    = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rad_r  <= acc_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? (rem_t - trial) : rem_t;
      root_r <= {root_r[ROOT_BITS-2:0], ge};
    end
  end

  // Running minimum; a later template wins only when strictly closer.
  logic [ROOT_BITS-1:0] bestd_r;
  logic [CLASS_W-1:0]   bestc_r;

  always_ff @(posedge clk) begin
    if (cmd.best_upd && (cmd.tmpl == 2'd0 || root_r < bestd_r)) begin
      bestd_r <= root_r;
      bestc_r <= cmd.tmpl;
    end
  end

  // Final decision and match tracking.
  logic [BUTTON_W-1:0] prev_btn_r;
  logic [2:0]          cur_cls_r, cur_cls_nxt;
  logic [HOLD_W-1:0]   run_r, run_nxt;
  action_t             act;
  logic [CMP_W-1:0]    bd_ext;
  logic                is_match;
  logic [DIST_W-1:0]   dist_sat;

  assign bd_ext   = CMP_W'(bestd_r);
  assign is_match = stat.classify && (bd_ext < CMP_W'(thr_r));
  assign dist_sat = (bd_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : bd_ext[DIST_W-1:0];

  always_comb begin
    act         = ACT_NONE;
    cur_cls_nxt = NO_CLASS;
    run_nxt     = '0;
    if (btn_r != prev_btn_r && btn_r != BTN_NONE) begin
      case (btn_r)
        BTN_UP:     act = ACT_UP;
        BTN_DOWN:   act = ACT_DOWN;
        BTN_ATTACK: act = ACT_ATTACK;
        default:    act = ACT_NONE;
      endcase
    end
    if (is_match) begin
      cur_cls_nxt = {1'b0, bestc_r};
      if (cur_cls_r == {1'b0, bestc_r}) begin
        run_nxt = (run_r < RUN_MAX) ? run_r + 8'd1 : run_r;
      end else begin
        run_nxt = 8'd1;
      end
      if (run_nxt >= hold_r) begin
        act         = action_t'(ACTION_W'(bestc_r) + 3'd1);
        cur_cls_nxt = NO_CLASS;
        run_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_btn_r <= BTN_NONE;
      cur_cls_r  <= NO_CLASS;
      run_r      <= '0;
    end else if (cmd.commit) begin
      prev_btn_r <= btn_r;
      cur_cls_r  <= cur_cls_nxt;
      run_r      <= run_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_action        <= act;
      out_best_class    <= stat.classify ? bestc_r : '0;
      out_best_distance <= stat.classify ? dist_sat : '0;
      out_classified    <= stat.classify;
    end
  end

endmodule

// File: src/nearest_template_classifier_with_hold_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    sample_a..d (8b each), button_status (4b)
// out_      output     out_valid/out_ready  action (3b), best_class (2b),
//                                           best_distance (9b), classified (1b)
// cfg_      input      cfg_valid/cfg_ready  cfg_index (3b), cfg_data (32b)
//
// A classifying transaction (button status 8) runs through one shared squarer
// that visits the four channels of each template in turn, followed by a square
// root unit that yields one root bit per cycle. Any other button status goes
// straight from the button check to the result register. The next transaction
// can be accepted once the controller is back in its idle state.
// Reset is synchronous and active low; it restores the register defaults
// and clears the match run. A new transaction is taken while a finished
// result still waits in the output register; the finished work then holds
// until that result is taken. Configuration writes are always accepted.

module nearest_template_classifier_with_hold_unit #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ntc_pkg::SAMPLE_W-1:0]  in_sample_a,
  input  logic [ntc_pkg::SAMPLE_W-1:0]  in_sample_b,
  input  logic [ntc_pkg::SAMPLE_W-1:0]  in_sample_c,
  input  logic [ntc_pkg::SAMPLE_W-1:0]  in_sample_d,
  input  logic [ntc_pkg::BUTTON_W-1:0]  in_button_status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ntc_pkg::ACTION_W-1:0]  out_action,
  output logic [ntc_pkg::CLASS_W-1:0]   out_best_class,
  output logic [ntc_pkg::DIST_W-1:0]    out_best_distance,
  output logic                          out_classified,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ntc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ntc_pkg::TMPL_W-1:0]    cfg_data
);
  import ntc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  // The controller sequences the channel, root and compare steps.
  ntc_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the squarer, the root unit and the
  // match tracking.
  ntc_dp #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_sample_a      (in_sample_a),
    .in_sample_b      (in_sample_b),
    .in_sample_c      (in_sample_c),
    .in_sample_d      (in_sample_d),
    .in_button_status (in_button_status),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_action       (out_action),
    .out_best_class   (out_best_class),
    .out_best_distance(out_best_distance),
    .out_classified   (out_classified)
  );

endmodule

// File: src/ntc_checker.sv
`timescale 1ns / 1ps

module ntc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ntc_pkg::ACTION_W-1:0]  out_action,
  input logic [ntc_pkg::CLASS_W-1:0]   out_best_class,
  input logic [ntc_pkg::DIST_W-1:0]    out_best_distance,
  input logic                          out_classified
);
  import ntc_pkg::*;

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
      $stable(out_best_class) && $stable(out_best_distance) && $stable(out_classified))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Without classification the class fields stay zero.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_classified |-> out_best_class == '0 && out_best_distance == '0)
    else $error("class fields set without classification");

  // A classified result fires nothing or the action of its own class.
  a_class_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_classified |->
      out_action == ACT_NONE || out_action == (ACTION_W'(out_best_class) + 3'd1))
    else $error("action does not match the winning class");

  // Without classification no bonus action can arise.
  a_no_bonus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_classified |-> out_action != ACT_BONUS)
    else $error("bonus action without classification");

endmodule

bind nearest_template_classifier_with_hold_unit ntc_checker u_ntc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_action       (out_action),
  .out_best_class   (out_best_class),
  .out_best_distance(out_best_distance),
  .out_classified   (out_classified)
);
